FILE: rtl/vag_pkg.sv
// Shared types and codes for the vector autoregression generator.
package vag_pkg;

	// Item kinds on the input channel
	typedef enum logic [1:0] {
		KIND_LOAD    = 2'd0,
		KIND_SAMPLE  = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_FINISH,
		ST_COMMIT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;    // write one coefficient
		logic clear;   // clear history, pending values and channel count
		logic start;   // take the innovation and seed the accumulator
		logic issue;   // read one coefficient and one history term
		logic finish;  // round, saturate, store pending, present result
		logic commit;  // shift history by one lag, pending becomes lag 1
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic term_last; // current term is the last of the channel's row
		logic row_last;  // current channel is the last of the time step
		logic out_free;  // output register can take a new beat
	} sts_t;

	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned COEF_W   = 18;
	localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
	localparam int unsigned ACC_W    = 64;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned INDEX_W  = 6;

endpackage

FILE: rtl/vector_autoregression_generator.sv
// Top level of the multichannel VAR(k) series generator.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  input   | in        | in_valid / in_stall  | kind, coef_index, coef_value, sample
//  output  | out       | out_valid / out_stall| value, channel, step_done
//
// Load and restart beats are taken straight from idle. A sample beat walks the
// shared multiply-accumulate one history term per cycle, then passes a two-stage
// read/multiply drain and a round/saturate state; the last channel of a step adds
// a commit state to shift the history. Reset clears history, pending values
// and the channel count; the coefficient memory holds no reset value.
// A result waits in the output register under out_stall; the next beat is taken
// meanwhile, and its result waits in the round cycle until the register frees.
module vector_autoregression_generator #(
	parameter int unsigned CHANNELS = 4,
	parameter int unsigned LAGS     = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [5:0]         coef_index,
	input  logic signed [17:0] coef_value,
	input  logic signed [31:0] sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic [1:0]         channel,
	output logic               step_done
);

	vag_pkg::cmd_t cmd;
	vag_pkg::sts_t sts;

	// Sequence the work
	vag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// Compute the values
	vag_datapath #(
		.CHANNELS (CHANNELS),
		.LAGS     (LAGS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.sample     (sample),
		.out_stall  (out_stall),
		.sts        (sts),
		.out_valid  (out_valid),
		.value      (value),
		.channel    (channel),
		.step_done  (step_done)
	);

`ifndef ASSERT_OFF
	// A sample beat locks the input side the next cycle
	a_sample_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (kind == vag_pkg::KIND_SAMPLE)) |=> in_stall)
		else $error("input taken while a sample is in work");

	// A new output beat appears only after the round cycle
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.finish))
		else $error("output beat without a finished sample");

	// History shifts only right after the last channel finished
	a_commit_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> ($past(cmd.finish) && step_done))
		else $error("history shift out of order");

	// The MAC walk never runs while input beats are taken
	a_issue_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> in_stall)
		else $error("MAC issue while input open");
`endif

endmodule

FILE: rtl/vag_ctrl.sv
// Controller state machine: sequences loads, restarts and the per-sample MAC walk.
module vag_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       kind,
	input  vag_pkg::sts_t    sts,
	output logic             in_stall,
	output vag_pkg::cmd_t    cmd
);

	vag_pkg::state_t state_q;
	vag_pkg::state_t state_d;
	logic            accept;

	assign accept = in_valid && (state_q == vag_pkg::ST_IDLE);

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vag_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vag_pkg::ST_IDLE: begin
				if (accept && (kind == vag_pkg::KIND_SAMPLE)) begin
					state_d = vag_pkg::ST_MAC;
				end
			end
			vag_pkg::ST_MAC: begin
				if (sts.term_last) begin
					state_d = vag_pkg::ST_DRAIN1;
				end
			end
			vag_pkg::ST_DRAIN1: begin
				state_d = vag_pkg::ST_DRAIN2;
			end
			vag_pkg::ST_DRAIN2: begin
				state_d = vag_pkg::ST_FINISH;
			end
			vag_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					state_d = sts.row_last ? vag_pkg::ST_COMMIT : vag_pkg::ST_IDLE;
				end
			end
			vag_pkg::ST_COMMIT: begin
				state_d = vag_pkg::ST_IDLE;
			end
			default: begin
				state_d = vag_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			vag_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (kind)
						vag_pkg::KIND_LOAD:    cmd.load  = 1'b1;
						vag_pkg::KIND_SAMPLE:  cmd.start = 1'b1;
						vag_pkg::KIND_RESTART: cmd.clear = 1'b1;
						default:               cmd       = '0;
					endcase
				end
			end
			vag_pkg::ST_MAC: begin
				cmd.issue = 1'b1;
			end
			vag_pkg::ST_FINISH: begin
				cmd.finish = sts.out_free;
			end
			vag_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/vag_datapath.sv
// Datapath: coefficient memory, history shift line, shared MAC and output register.
module vag_datapath #(
	parameter int unsigned CHANNELS = 4,
	parameter int unsigned LAGS     = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vag_pkg::cmd_t        cmd,
	input  logic [5:0]           coef_index,
	input  logic signed [17:0]   coef_value,
	input  logic signed [31:0]   sample,
	input  logic                 out_stall,
	output vag_pkg::sts_t        sts,
	output logic                 out_valid,
	output logic signed [31:0]   value,
	output logic [1:0]           channel,
	output logic                 step_done
);

	localparam int unsigned TERMS      = CHANNELS * LAGS;
	localparam int unsigned TABLE_SIZE = CHANNELS * TERMS;
	localparam int unsigned COEF_DEPTH = (TABLE_SIZE < 64) ? TABLE_SIZE : 64;
	localparam int unsigned COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
	localparam int unsigned ROW_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned TERM_W     = (TERMS > 1) ? $clog2(TERMS) : 1;

	// Coefficient memory
	logic signed [17:0] coef_mem [COEF_DEPTH];

	// History line: entry lag*CHANNELS + column, rotated during the MAC walk
	logic signed [31:0] hist_q [TERMS];
	logic signed [31:0] pend_q [CHANNELS];

	logic [ROW_W-1:0]   row_q;
	logic [TERM_W-1:0]  term_q;
	logic [31:0]        rd_addr;
	logic               row_last;

	// MAC pipeline
	logic                 vld_s1;
	logic                 vld_s2;
	logic signed [17:0]   coef_s1;
	logic signed [31:0]   hist_s1;
	logic signed [49:0]   prod_s2;
	logic signed [63:0]   acc_q;

	// Rounding and saturation
	logic signed [63:0]   rnd;
	logic signed [63:0]   shr;
	logic signed [31:0]   sat;

	logic                 out_valid_q;
	logic signed [31:0]   value_q;
	logic [1:0]           channel_q;
	logic                 step_done_q;

	assign rd_addr  = 32'(row_q) * 32'(TERMS) + 32'(term_q);
	assign row_last = (row_q == ROW_W'(CHANNELS - 1));

	assign sts.term_last = (term_q == TERM_W'(TERMS - 1));
	assign sts.row_last  = row_last;
	assign sts.out_free  = !out_valid_q || !out_stall;

	// Write one coefficient; ignore addresses beyond the table
	always_ff @(posedge clk) begin
		if (cmd.load && (32'(coef_index) < 32'(TABLE_SIZE))) begin
			coef_mem[coef_index[COEF_AW-1:0]] <= coef_value;
		end
	end

	// Read one coefficient and the history head each issue cycle
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			coef_s1 <= coef_mem[rd_addr[COEF_AW-1:0]];
			hist_s1 <= hist_q[0];
		end
		prod_s2 <= coef_s1 * hist_s1;
	end

	// Advance the MAC valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	// Seed with the innovation, then accumulate products
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= $signed({{16{sample[31]}}, sample, 16'b0});
		end else if (vld_s2) begin
			acc_q <= acc_q + 64'(prod_s2);
		end
	end

	// Walk the terms of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= '0;
		end else if (cmd.start) begin
			term_q <= '0;
		end else if (cmd.issue) begin
			term_q <= term_q + TERM_W'(1);
		end
	end

	// Round half up, then saturate to 32 bits
	always_comb begin
		rnd = acc_q + 64'sd32768;
		shr = rnd >>> vag_pkg::FRAC_W;
		if (shr > 64'sd2147483647) begin
			sat = 32'sh7fffffff;
		end else if (shr < -64'sd2147483648) begin
			sat = 32'sh80000000;
		end else begin
			sat = shr[31:0];
		end
	end

	// Rotate history during the walk, shift in pending values on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TERMS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < TERMS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (cmd.issue) begin
			for (int i = 0; i < TERMS - 1; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[TERMS-1] <= hist_q[0];
		end else if (cmd.commit) begin
			for (int i = CHANNELS; i < TERMS; i++) begin
				hist_q[i] <= hist_q[i-CHANNELS];
			end
			for (int i = 0; i < CHANNELS; i++) begin
				hist_q[i] <= pend_q[i];
			end
		end
	end

	// Store the new value as pending and advance the channel count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				pend_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			row_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				pend_q[i] <= '0;
			end
		end else if (cmd.finish) begin
			pend_q[row_q] <= sat;
			row_q <= row_last ? '0 : row_q + ROW_W'(1);
		end
	end

	// Output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			value_q     <= sat;
			channel_q   <= 2'(row_q);
			step_done_q <= row_last;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign channel   = channel_q;
	assign step_done = step_done_q;

endmodule
